### rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants of the rectangle transform block
// Command codes, widths, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int COORD_W = 16;
    localparam int COORD_FRAC_BITS = 12;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W = 5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0] size_t;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_ROTATE    = 2'd1,
        CMD_SCALE     = 2'd2,
        CMD_HIT       = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BBOX,
        ST_ANGLE,
        ST_CORDIC,
        ST_ROT_MUL,
        ST_ROT_ACC,
        ST_ROT_WR,
        ST_SCALE_MUL,
        ST_SCALE_WR,
        ST_DONE
    } state_t;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0] FULL_TURN = 16'sd23040;
    localparam logic signed [15:0] HALF_TURN = 16'sd11520;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;

    // quarter and half of one unit, saturated to the coordinate range
    localparam int QUARTER_RAW = 1 << (COORD_FRAC_BITS - 2);
    localparam int HALF_RAW = 1 << (COORD_FRAC_BITS - 1);
    localparam coord_t QUARTER = (QUARTER_RAW > 32767) ? 16'sh7fff : COORD_W'(QUARTER_RAW);
    localparam size_t HALF = (HALF_RAW > 65535) ? 16'hffff : COORD_W'(HALF_RAW);

    // arctangent of 2^-i in degrees, Q.16
    function automatic logic signed [33:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0: r = 34'sd2949120;
                5'd1: r = 34'sd1740967;
                5'd2: r = 34'sd919879;
                5'd3: r = 34'sd466945;
                5'd4: r = 34'sd234379;
                5'd5: r = 34'sd117304;
                5'd6: r = 34'sd58666;
                5'd7: r = 34'sd29335;
                5'd8: r = 34'sd14668;
                5'd9: r = 34'sd7334;
                5'd10: r = 34'sd3667;
                5'd11: r = 34'sd1833;
                5'd12: r = 34'sd917;
                5'd13: r = 34'sd458;
                5'd14: r = 34'sd229;
                5'd15: r = 34'sd115;
                5'd16: r = 34'sd57;
                5'd17: r = 34'sd29;
                5'd18: r = 34'sd14;
                5'd19: r = 34'sd7;
                5'd20: r = 34'sd4;
                5'd21: r = 34'sd2;
                5'd22: r = 34'sd1;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic coord_t sat_s16(input logic signed [49:0] v);
        begin
            if (v > 50'sd32767)
                return 16'sh7fff;
            else if (v < -50'sd32768)
                return 16'sh8000;
            else
                return v[15:0];
        end
    endfunction

endpackage

### rtl/rth_if.sv
// ----------------------------------------------------------------------------
// rth_cmd_if / rth_res_if: valid/ready channels of the rectangle block
// One command item in, one result item out.
// ----------------------------------------------------------------------------
interface rth_cmd_if;
    logic valid;
    logic ready;
    logic [1:0] cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rotate_angle;
    logic [15:0] scale_factor;

    modport source (output valid, cmd, pos_x, pos_y, rotate_angle, scale_factor,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, rotate_angle, scale_factor,
                  output ready);
endinterface

interface rth_res_if;
    logic valid;
    logic ready;
    logic signed [15:0] bl_x;
    logic signed [15:0] bl_y;
    logic signed [15:0] br_x;
    logic signed [15:0] br_y;
    logic signed [15:0] tr_x;
    logic signed [15:0] tr_y;
    logic signed [15:0] tl_x;
    logic signed [15:0] tl_y;
    logic inside_res;
    logic [15:0] box_width;
    logic [15:0] box_height;

    modport source (output valid, bl_x, bl_y, br_x, br_y, tr_x, tr_y, tl_x, tl_y,
                    inside_res, box_width, box_height, input ready);
    modport sink (input valid, bl_x, bl_y, br_x, br_y, tr_x, tr_y, tl_x, tl_y,
                  inside_res, box_width, box_height, output ready);
endinterface

### rtl/rect_transform_hit_test.sv
// ----------------------------------------------------------------------------
// rect_transform_hit_test: quadrilateral transform and hit test
// Sequencer around one shared 32x17 multiplier and one CORDIC add/shift stage.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_in carries one command item (translate, rotate, scale, hit test);
//   res_out returns one result item per command with all four corners,
//   the hit verdict and the nominal sizes.
//   One item at a time: cmd_in.ready is high only while idle.
//   Sequencer states per command: translate and hit test pass through the
//   bounding box and done; scale adds two multiplies and a size write;
//   rotate adds the angle reduction, the CORDIC loop (one step a cycle) and,
//   per corner, four multiply/accumulate pairs and a write, the one shared
//   multiplier forming the four products of each corner in turn, each product
//   being added in the following cycle. A new command is taken only in idle.
//   The result is copied into an output register and held there until
//   res_out.ready; meanwhile the next command is taken and worked, and the
//   sequencer waits in its last state until the output register is free.
//   Reset puts the corners at +/-0.25 and both sizes at 0.5.
// ----------------------------------------------------------------------------
module rect_transform_hit_test (
    input  logic clk,
    input  logic rst_n,
    rth_cmd_if.sink   cmd_in,
    rth_res_if.source res_out
);
    import rth_pkg::*;

    state_t state_reg, state_next;
    coord_t cx_reg [4];
    coord_t cy_reg [4];
    size_t wid_reg, hgt_reg;
    logic [1:0] cmd_reg;
    coord_t px_reg, py_reg;
    logic signed [15:0] ang_reg;
    logic [15:0] sf_reg;
    logic inside_reg;
    logic res_valid_reg;
    coord_t res_x_reg [4];
    coord_t res_y_reg [4];
    logic res_inside_reg;
    size_t res_w_reg, res_h_reg;
    logic signed [16:0] ctx_reg, cty_reg;
    logic flip_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [STEP_W-1:0] step_reg;
    logic [1:0] k_reg;
    logic [1:0] m_reg;
    logic signed [67:0] prod_reg;
    logic signed [69:0] accx_reg, accy_reg;
    logic signed [33:0] cs_reg, sn_reg;

    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [16:0] dx, dy;
    logic signed [15:0] red;

    // centre offsets of the corner in work
    assign dx = 17'(cx_reg[k_reg]) - ctx_reg;
    assign dy = 17'(cy_reg[k_reg]) - cty_reg;

    // angle brought within one turn, truncating toward zero
    assign red = (ang_reg >= FULL_TURN) ? ang_reg - FULL_TURN
               : (ang_reg <= -FULL_TURN) ? ang_reg + FULL_TURN : ang_reg;

    // last CORDIC step result, cosine or sine
    function automatic logic signed [33:0] x_reg_next(input logic want_x);
        logic signed [33:0] nx, ny;
        begin
            if (!z_reg[33])
            begin
                nx = x_reg - (y_reg >>> step_reg);
                ny = y_reg + (x_reg >>> step_reg);
            end
            else
            begin
                nx = x_reg + (y_reg >>> step_reg);
                ny = y_reg - (x_reg >>> step_reg);
            end
            return want_x ? nx : ny;
        end
    endfunction

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SCALE_MUL)
        begin
            mul_a = (m_reg == 2'd0) ? 32'(wid_reg) : 32'(hgt_reg);
            mul_b = 17'(sf_reg);
        end
        else
        begin
            case (m_reg)
                2'd0: begin mul_a = 32'(cs_reg); mul_b = dx; end
                2'd1: begin mul_a = 32'(sn_reg); mul_b = dy; end
                2'd2: begin mul_a = 32'(sn_reg); mul_b = dx; end
                default: begin mul_a = 32'(cs_reg); mul_b = dy; end
            endcase
        end
    end

    // the one multiplier
    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_in.valid)
                    state_next = ST_BBOX;
            ST_BBOX:
                case (cmd_t'(cmd_reg))
                    CMD_ROTATE: state_next = ST_ANGLE;
                    CMD_SCALE: state_next = ST_SCALE_MUL;
                    default: state_next = ST_DONE;
                endcase
            ST_ANGLE: state_next = ST_CORDIC;
            ST_CORDIC:
                if (32'(step_reg) == CORDIC_STEPS - 1)
                    state_next = ST_ROT_MUL;
            ST_ROT_MUL: state_next = ST_ROT_ACC;
            ST_ROT_ACC:
                state_next = (m_reg == 2'd3) ? ST_ROT_WR : ST_ROT_MUL;
            ST_ROT_WR:
                state_next = (k_reg == 2'd3) ? ST_DONE : ST_ROT_MUL;
            ST_SCALE_MUL:
                if (m_reg == 2'd1)
                    state_next = ST_SCALE_WR;
            ST_SCALE_WR: state_next = ST_DONE;
            ST_DONE:
                if (!res_valid_reg || res_out.ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg[0] <= -QUARTER; cx_reg[1] <= QUARTER;
            cx_reg[2] <= QUARTER;  cx_reg[3] <= -QUARTER;
            cy_reg[0] <= -QUARTER; cy_reg[1] <= -QUARTER;
            cy_reg[2] <= QUARTER;  cy_reg[3] <= QUARTER;
            wid_reg <= HALF;
            hgt_reg <= HALF;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                res_x_reg[i] <= '0;
                res_y_reg[i] <= '0;
            end
            res_inside_reg <= 1'b0;
            res_w_reg <= '0;
            res_h_reg <= '0;
            inside_reg <= 1'b0;
            step_reg <= '0;
            k_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            // output register handshake
            if (state_reg == ST_DONE && (!res_valid_reg || res_out.ready))
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res_out.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (cmd_in.valid)
                    begin
                        cmd_reg <= cmd_in.cmd;
                        px_reg <= cmd_in.pos_x;
                        py_reg <= cmd_in.pos_y;
                        ang_reg <= cmd_in.rotate_angle;
                        sf_reg <= cmd_in.scale_factor;
                        step_reg <= '0;
                        k_reg <= '0;
                        m_reg <= '0;
                    end
                ST_BBOX:
                begin
                    // four-way min/max, narrow compares
                    begin
                        coord_t a, b, c, d;
                        a = cx_reg[0]; b = cx_reg[0]; c = cy_reg[0]; d = cy_reg[0];
                        for (int i = 1; i < 4; i++)
                        begin
                            if (cx_reg[i] < a) a = cx_reg[i];
                            if (cx_reg[i] > b) b = cx_reg[i];
                            if (cy_reg[i] < c) c = cy_reg[i];
                            if (cy_reg[i] > d) d = cy_reg[i];
                        end
                        ctx_reg <= 17'((18'(a) + 18'(b)) >>> 1);
                        cty_reg <= 17'((18'(c) + 18'(d)) >>> 1);
                        inside_reg <= (cmd_t'(cmd_reg) == CMD_HIT) &&
                                      (a <= px_reg) && (px_reg <= b) &&
                                      (c <= py_reg) && (py_reg <= d);
                        case (cmd_t'(cmd_reg))
                            CMD_TRANSLATE:
                                for (int i = 0; i < 4; i++)
                                begin
                                    cx_reg[i] <= sat_s16(50'(cx_reg[i]) + 50'(px_reg));
                                    cy_reg[i] <= sat_s16(50'(cy_reg[i]) + 50'(py_reg));
                                end
                            default: ;
                        endcase
                    end
                end
                ST_ANGLE:
                begin
                    logic signed [15:0] a;
                    logic fl;
                    a = red;
                    fl = 1'b0;
                    if (a > HALF_TURN) a = a - FULL_TURN;
                    if (a < -HALF_TURN) a = a + FULL_TURN;
                    if (a > QUARTER_TURN)
                    begin
                        a = a - HALF_TURN; fl = 1'b1;
                    end
                    else if (a < -QUARTER_TURN)
                    begin
                        a = a + HALF_TURN; fl = 1'b1;
                    end
                    flip_reg <= fl;
                    z_reg <= 34'(a) <<< 10;
                    x_reg <= CORDIC_GAIN;
                    y_reg <= '0;
                end
                ST_CORDIC:
                begin
                    // one micro-rotation per cycle
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - (y_reg >>> step_reg);
                        y_reg <= y_reg + (x_reg >>> step_reg);
                        z_reg <= z_reg - atan_lut(step_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + (y_reg >>> step_reg);
                        y_reg <= y_reg - (x_reg >>> step_reg);
                        z_reg <= z_reg + atan_lut(step_reg);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (32'(step_reg) == CORDIC_STEPS - 1)
                    begin
                        cs_reg <= flip_reg ? -x_reg_next(1'b1) : x_reg_next(1'b1);
                        sn_reg <= flip_reg ? -x_reg_next(1'b0) : x_reg_next(1'b0);
                    end
                end
                ST_ROT_MUL:
                    prod_reg <= 68'(mul_p);
                ST_ROT_ACC:
                begin
                    case (m_reg)
                        2'd0: accx_reg <= 70'(prod_reg) + (70'sd1 <<< 29);
                        2'd1: accx_reg <= accx_reg - 70'(prod_reg);
                        2'd2: accy_reg <= 70'(prod_reg) + (70'sd1 <<< 29);
                        default: accy_reg <= accy_reg + 70'(prod_reg);
                    endcase
                    m_reg <= m_reg + 1'b1;
                end
                ST_ROT_WR:
                begin
                    cx_reg[k_reg] <= sat_s16(50'(ctx_reg) + 50'(accx_reg >>> 30));
                    cy_reg[k_reg] <= sat_s16(50'(cty_reg) + 50'(accy_reg >>> 30));
                    k_reg <= k_reg + 1'b1;
                end
                ST_SCALE_MUL:
                begin
                    logic [32:0] s;
                    s = (33'(mul_p[31:0]) + 33'd128) >> 8;
                    if (m_reg == 2'd0)
                        wid_reg <= (s > 33'd65535) ? 16'hffff : s[15:0];
                    else
                        hgt_reg <= (s > 33'd65535) ? 16'hffff : s[15:0];
                    m_reg <= m_reg + 1'b1;
                end
                ST_SCALE_WR:
                begin
                    logic signed [49:0] hw, hh;
                    hw = 50'(wid_reg >> 1);
                    hh = 50'(hgt_reg >> 1);
                    cx_reg[0] <= sat_s16(50'(ctx_reg) - hw);
                    cx_reg[3] <= sat_s16(50'(ctx_reg) - hw);
                    cx_reg[1] <= sat_s16(50'(ctx_reg) + hw);
                    cx_reg[2] <= sat_s16(50'(ctx_reg) + hw);
                    cy_reg[0] <= sat_s16(50'(cty_reg) - hh);
                    cy_reg[1] <= sat_s16(50'(cty_reg) - hh);
                    cy_reg[2] <= sat_s16(50'(cty_reg) + hh);
                    cy_reg[3] <= sat_s16(50'(cty_reg) + hh);
                end
                ST_DONE:
                    // copy the finished item into the output register
                    if (!res_valid_reg || res_out.ready)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            res_x_reg[i] <= cx_reg[i];
                            res_y_reg[i] <= cy_reg[i];
                        end
                        res_inside_reg <= inside_reg;
                        res_w_reg <= wid_reg;
                        res_h_reg <= hgt_reg;
                    end
                default: ;
            endcase
        end
    end

    assign cmd_in.ready = (state_reg == ST_IDLE);
    assign res_out.valid = res_valid_reg;
    assign res_out.bl_x = res_x_reg[0];
    assign res_out.bl_y = res_y_reg[0];
    assign res_out.br_x = res_x_reg[1];
    assign res_out.br_y = res_y_reg[1];
    assign res_out.tr_x = res_x_reg[2];
    assign res_out.tr_y = res_y_reg[2];
    assign res_out.tl_x = res_x_reg[3];
    assign res_out.tl_y = res_y_reg[3];
    assign res_out.inside_res = res_inside_reg;
    assign res_out.box_width = res_w_reg;
    assign res_out.box_height = res_h_reg;

    // input only taken while idle
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_in.ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    // inside flag only for hit tests
    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && inside_reg |-> cmd_reg == CMD_HIT)
        else $error("inside set on non-hit command");
    // a waiting result stays put until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid &&
        $stable({res_out.bl_x, res_out.bl_y, res_out.br_x, res_out.br_y,
                 res_out.tr_x, res_out.tr_y, res_out.tl_x, res_out.tl_y,
                 res_out.inside_res, res_out.box_width, res_out.box_height}))
        else $error("result changed while waiting");
    // cordic count stays in range
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CORDIC |-> 32'(step_reg) < CORDIC_STEPS)
        else $error("cordic step overrun");

endmodule
